@@ rtl/swmm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

   localparam int HISTORY_DEPTH_DEF = 30;
   localparam int SAMPLE_BITS_DEF   = 16;

   localparam int RESULT_BITS    = 20;
   localparam int COUNT_BITS     = 5;
   localparam int FRAC_BITS      = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [RESULT_BITS-1:0]   RESULT_MAX   = 20'hFFFFF;
   localparam logic [CSR_DATA_BITS-1:0] WINDOW_RESET = 5'd20;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW = 2'd1;

   localparam logic MODE_MEAN   = 1'b0;
   localparam logic MODE_MEDIAN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DIVIDE,
      ST_FINISH
   } swmm_state_type;

endpackage

`default_nettype wire

@@ rtl/swmm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/swmm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swmm_div #(
   parameter int DIVIDEND_BITS = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [DIVIDEND_BITS-1:0]            dividend,
   input  logic [swmm_pkg::COUNT_BITS-1:0]     divisor,
   output logic                                done,
   output logic [DIVIDEND_BITS-1:0]            quotient
);
   import swmm_pkg::*;

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS:0]      trial;
   logic                     fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits    = trial >= {1'b0, divisor};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? COUNT_BITS'(trial - {1'b0, divisor}) : COUNT_BITS'(trial);
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/sliding_window_mean_median.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Moving mean / median over the newest window_length samples of a history of
// HISTORY_DEPTH samples. Each transfer on req_ stores the sample, then walks the
// window through the history RAM, one read per cycle, and returns one result
// on rsp_ (value times 16, truncated) with the number of samples used. The
// block takes one sample at a time. Mean: n window reads followed by a
// one-bit-per-cycle divider. Median: one window walk per sample bit to
// settle the two middle ranks bit by bit. A finished result waits in the
// output register, so the next sample may be taken while it waits.

module sliding_window_mean_median #(
   parameter int HISTORY_DEPTH = swmm_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS   = swmm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_BITS-1:0]                req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [swmm_pkg::RESULT_BITS-1:0]      rsp_filtered_x16,
   output logic [swmm_pkg::COUNT_BITS-1:0]       rsp_used_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swmm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [swmm_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import swmm_pkg::*;

   localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);
   localparam int FILL_BITS     = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_BITS      = (FILL_BITS > COUNT_BITS) ? FILL_BITS : COUNT_BITS;
   localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
   localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
   localparam int PAIR_BITS     = SAMPLE_BITS + 1;
   localparam int MED_BITS      = PAIR_BITS + FRAC_BITS - 1;
   localparam int WIDE_BITS     = DIVIDEND_BITS + RESULT_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(HISTORY_DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(HISTORY_DEPTH);

   swmm_state_type state_ff, state_in;

   logic                     mode_ff, mode_in;
   logic [CSR_DATA_BITS-1:0] window_ff, window_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [ADDR_BITS-1:0]     slot_ff, slot_in;
   logic [ADDR_BITS-1:0]     start_addr_ff, start_addr_in;
   logic [ADDR_BITS-1:0]     addr_ff, addr_in;
   logic [COUNT_BITS-1:0]    issued_ff, issued_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [COUNT_BITS-1:0]    n_ff, n_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]   bitsel_ff, bitsel_in;
   logic [SAMPLE_BITS-1:0]   mask_ff, mask_in;
   logic [SAMPLE_BITS-1:0]   pre_lo_ff, pre_lo_in;
   logic [SAMPLE_BITS-1:0]   pre_hi_ff, pre_hi_in;
   logic [COUNT_BITS-1:0]    rank_lo_ff, rank_lo_in;
   logic [COUNT_BITS-1:0]    rank_hi_ff, rank_hi_in;
   logic [COUNT_BITS-1:0]    cnt_lo_ff, cnt_lo_in;
   logic [COUNT_BITS-1:0]    cnt_hi_ff, cnt_hi_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0]   rsp_result_ff, rsp_result_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   logic                     accept;
   logic                     issue;
   logic                     sweep_end;
   logic                     div_start;
   logic                     div_done;
   logic [DIVIDEND_BITS-1:0] quotient;
   logic [SAMPLE_BITS-1:0]   rd_data;
   logic [FILL_BITS-1:0]     fill_next;
   logic [COUNT_BITS-1:0]    wl_c;
   logic [CMP_BITS-1:0]      w_c;
   logic [COUNT_BITS-1:0]    n_next;
   logic                     zero_bit;
   logic                     lo_match;
   logic                     hi_match;
   logic [PAIR_BITS-1:0]     pair_sum;
   logic [MED_BITS-1:0]      med_x16;
   logic [WIDE_BITS-1:0]     wide_c;
   logic [RESULT_BITS-1:0]   result_c;

   swmm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_sample),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   swmm_div #(
      .DIVIDEND_BITS (DIVIDEND_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, FRAC_BITS'(0)}),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign issue     = (state_ff == ST_SWEEP) && (issued_ff != n_ff);
   assign sweep_end = (state_ff == ST_SWEEP) && (issued_ff == n_ff) && !rd_pend_ff;

   always_comb begin
      fill_next = (fill_ff == FULL_FILL) ? fill_ff : fill_ff + 1'b1;
      wl_c      = (window_ff == '0) ? COUNT_BITS'(1) : window_ff;
      w_c       = CMP_BITS'(wl_c);
      if (w_c > CMP_BITS'(HISTORY_DEPTH)) begin
         w_c = CMP_BITS'(HISTORY_DEPTH);
      end
      if (w_c > CMP_BITS'(fill_next)) begin
         w_c = CMP_BITS'(fill_next);
      end
      n_next = COUNT_BITS'(w_c);
   end

   always_comb begin
      zero_bit = (rd_data & bitsel_ff) == '0;
      lo_match = (((rd_data ^ pre_lo_ff) & mask_ff) == '0) && zero_bit;
      hi_match = (((rd_data ^ pre_hi_ff) & mask_ff) == '0) && zero_bit;
      pair_sum = PAIR_BITS'(pre_lo_ff) + PAIR_BITS'(pre_hi_ff);
      med_x16  = {pair_sum, 3'b000};
      if (mode_ff == MODE_MEAN) begin
         wide_c = WIDE_BITS'(quotient);
      end else begin
         wide_c = WIDE_BITS'(med_x16);
      end
      if (wide_c > WIDE_BITS'(RESULT_MAX)) begin
         result_c = RESULT_MAX;
      end else begin
         result_c = wide_c[RESULT_BITS-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      window_in     = window_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      start_addr_in = start_addr_ff;
      addr_in       = addr_ff;
      issued_in     = issued_ff;
      rd_pend_in    = issue;
      n_in          = n_ff;
      sum_in        = sum_ff;
      bitsel_in     = bitsel_ff;
      mask_in       = mask_ff;
      pre_lo_in     = pre_lo_ff;
      pre_hi_in     = pre_hi_ff;
      rank_lo_in    = rank_lo_ff;
      rank_hi_in    = rank_hi_ff;
      cnt_lo_in     = cnt_lo_ff;
      cnt_hi_in     = cnt_hi_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_count_in  = rsp_count_ff;
      div_start     = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:   mode_in   = csr_data[0];
            CSR_WINDOW: window_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // advance the window walk, newest sample first
      if (issue) begin
         addr_in   = (addr_ff == '0) ? LAST_ADDR : addr_ff - 1'b1;
         issued_in = issued_ff + 1'b1;
      end
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_BITS'(rd_data);
         if (lo_match) begin
            cnt_lo_in = cnt_lo_ff + 1'b1;
         end
         if (hi_match) begin
            cnt_hi_in = cnt_hi_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_in       = (slot_ff == LAST_ADDR) ? '0 : slot_ff + 1'b1;
               fill_in       = fill_next;
               n_in          = n_next;
               start_addr_in = slot_ff;
               addr_in       = slot_ff;
               issued_in     = '0;
               sum_in        = '0;
               cnt_lo_in     = '0;
               cnt_hi_in     = '0;
               bitsel_in     = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
               mask_in       = '0;
               pre_lo_in     = '0;
               pre_hi_in     = '0;
               rank_lo_in    = (n_next - 1'b1) >> 1;
               rank_hi_in    = n_next >> 1;
               state_in      = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_end) begin
               if (mode_ff == MODE_MEAN) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  // settle one bit of each middle rank, then walk again
                  if (rank_lo_ff >= cnt_lo_ff) begin
                     pre_lo_in  = pre_lo_ff | bitsel_ff;
                     rank_lo_in = rank_lo_ff - cnt_lo_ff;
                  end
                  if (rank_hi_ff >= cnt_hi_ff) begin
                     pre_hi_in  = pre_hi_ff | bitsel_ff;
                     rank_hi_in = rank_hi_ff - cnt_hi_ff;
                  end
                  mask_in   = mask_ff | bitsel_ff;
                  bitsel_in = bitsel_ff >> 1;
                  cnt_lo_in = '0;
                  cnt_hi_in = '0;
                  addr_in   = start_addr_ff;
                  issued_in = '0;
                  if (bitsel_ff[0]) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = result_c;
               rsp_count_in  = n_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_MEAN;
         window_ff    <= WINDOW_RESET;
         fill_ff      <= '0;
         slot_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_addr_ff <= start_addr_in;
      addr_ff       <= addr_in;
      issued_ff     <= issued_in;
      n_ff          <= n_in;
      sum_ff        <= sum_in;
      bitsel_ff     <= bitsel_in;
      mask_ff       <= mask_in;
      pre_lo_ff     <= pre_lo_in;
      pre_hi_ff     <= pre_hi_in;
      rank_lo_ff    <= rank_lo_in;
      rank_hi_ff    <= rank_hi_in;
      cnt_lo_ff     <= cnt_lo_in;
      cnt_hi_ff     <= cnt_hi_in;
      rsp_result_ff <= rsp_result_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_x16 = rsp_result_ff;
   assign rsp_used_count   = rsp_count_ff;

endmodule

`default_nettype wire

@@ rtl/swmm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swmm_checker #(
   parameter int HISTORY_DEPTH = swmm_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS   = swmm_pkg::SAMPLE_BITS_DEF
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [SAMPLE_BITS-1:0]                req_sample,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [swmm_pkg::RESULT_BITS-1:0]      rsp_filtered_x16,
   input logic [swmm_pkg::COUNT_BITS-1:0]       rsp_used_count,
   input logic                                  csr_valid,
   input logic                                  csr_ready,
   input logic [swmm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input logic [swmm_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import swmm_pkg::*;

   logic req_xfer;
   logic spare;

   assign req_xfer = req_valid && req_ready;
   assign spare    = ^{req_sample, csr_valid, csr_ready, csr_index, csr_data};

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("ready while a sample is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !$rose(rsp_valid))
      else $error("result one cycle after sample transfer");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_used_count != '0) &&
                    (int'(rsp_used_count) <= HISTORY_DEPTH) && (spare || !spare))
      else $error("used count out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_x16) &&
                                  $stable(rsp_used_count))
      else $error("stalled result changed");

endmodule

bind sliding_window_mean_median swmm_checker #(
   .HISTORY_DEPTH (HISTORY_DEPTH),
   .SAMPLE_BITS   (SAMPLE_BITS)
) u_swmm_checker (.*);

`default_nettype wire
